// ===== rtl/rbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpd_pkg
// Shared constants, types and pointer helpers for the ring buffer deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpd_pkg;

    localparam int STORE_DEPTH    = 64;
    localparam int PTR_W          = $clog2(STORE_DEPTH);
    localparam int CNT_W          = PTR_W + 1;
    localparam int BYTE_W         = 8;
    // frame length plus overhead needs one bit more than a byte
    localparam int TOT_W          = BYTE_W + 1;

    localparam int FRAME_OVERHEAD = 7;
    localparam int HEADER_BYTES   = 2;
    localparam int ID_OFFSET      = 2;
    localparam int REMAIN_OFFSET  = 3;
    localparam int CMD_OFFSET     = 4;
    localparam int LEN_OFFSET     = 5;
    localparam int DATA_OFFSET    = 6;

    localparam int MAX_RESULTS    = 63;
    localparam int RES_W          = $clog2(MAX_RESULTS + 1);

    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'hAA;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HUNT,
        ST_H0,
        ST_H1,
        ST_LEN,
        ST_SUM,
        ST_CHK,
        ST_EMPTY,
        ST_EMIT,
        ST_DONE
    } rbpd_state_t;

    // (p + off) modulo the store depth, off below the depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] off);
        logic [CNT_W-1:0] sum;
        sum = {1'b0, p} + {1'b0, off};
        if (sum >= CNT_W'(STORE_DEPTH))
            sum = sum - CNT_W'(STORE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] unread(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
        logic [CNT_W-1:0] n;
        if (wp >= rp)
            n = {1'b0, wp} - {1'b0, rp};
        else
            n = {1'b0, wp} + CNT_W'(STORE_DEPTH) - {1'b0, rp};
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rbpd_intf.sv =====
// ----------------------------------------------------------------------------
// rbpd channel interfaces
// Valid/ready channels for received items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbpd_rx_if import rbpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface rbpd_res_if import rbpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_id;
    logic [BYTE_W-1:0] remain_count;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] data_length;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              last;

    modport source (output valid, output packet_id, output remain_count,
                    output command_code, output data_length, output data_byte,
                    output has_data, output last, input ready);
    modport sink   (input valid, input packet_id, input remain_count,
                    input command_code, input data_length, input data_byte,
                    input has_data, input last, output ready);
endinterface

interface rbpd_cfg_if import rbpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbpd_ram.sv =====
// ----------------------------------------------------------------------------
// rbpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        // data holds while re is low
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ring_buffer_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_packet_deframer
// Ring store of received bytes with header hunt, XOR check and frame output.
// ----------------------------------------------------------------------------
// Received bytes go into a 64-entry ring store (at most 63 unread; a full
// store drops its oldest byte). After each written byte the block is busy
// while it scans: it drops bytes until the two header bytes lead, waits for a
// complete frame (head1 head2 id remain cmd length data check), checks the
// XOR and sends one result per payload byte, or one for an empty frame, up
// to 63 results per scan. All scanning goes through the single read port of
// the store, and no new byte is taken until the scan ends. A clear command
// needs no scan and leaves the block ready again at once.
`default_nettype none

module ring_buffer_packet_deframer
    import rbpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbpd_rx_if.sink     rx,
    rbpd_res_if.source  res,
    rbpd_cfg_if.sink    cfg
);

    rbpd_state_t state_reg, state_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [TOT_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] remain_reg, remain_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [RES_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [BYTE_W-1:0] hdr_first_reg, hdr_second_reg;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_id_reg, out_remain_reg, out_cmd_reg, out_len_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_has_reg, out_last_reg;

    logic              rd_en;
    logic [TOT_W-1:0]  rd_off;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;

    logic              load_out;
    logic [BYTE_W-1:0] load_data;
    logic              load_has;
    logic              load_last;

    logic              rx_fire;
    logic [CNT_W-1:0]  n_unread;
    logic [TOT_W-1:0]  n_ext;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  chk_idx;
    logic              slot_free;
    logic              drop;
    logic              emit_go;
    logic              last_byte;
    logic              sum_end;
    logic [BYTE_W-1:0] sum_new;

    assign rx_fire   = rx.valid && rx.ready;
    assign n_unread  = unread(wp_reg, rp_reg);
    assign n_ext     = TOT_W'(n_unread);
    assign total     = TOT_W'(len_reg) + TOT_W'(FRAME_OVERHEAD);
    assign chk_idx   = TOT_W'(len_reg) + TOT_W'(LEN_OFFSET);
    assign slot_free = !out_valid_reg || res.ready;
    assign drop      = res_cnt_reg >= RES_W'(MAX_RESULTS);
    assign emit_go   = slot_free || drop;
    assign last_byte = (idx_reg + TOT_W'(1)) == TOT_W'(len_reg);
    assign sum_end   = idx_reg == chk_idx;
    assign sum_new   = sum_reg ^ rd_data;
    assign rd_addr   = ptr_add(rp_reg, rd_off[PTR_W-1:0]);
    assign wr_en     = rx_fire && (rx.command == CMD_WRITE);

    rbpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wp_reg),
        .wdata (rx.rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire && rx.command == CMD_WRITE)
                    state_next = ST_HUNT;
            end
            ST_HUNT:
            begin
                if (n_unread < CNT_W'(2))
                    state_next = ST_IDLE;
                else
                    state_next = ST_H0;
            end
            ST_H0:
            begin
                if (rd_data != hdr_first_reg)
                    state_next = ST_HUNT;
                else
                    state_next = ST_H1;
            end
            ST_H1:
            begin
                if (rd_data != hdr_second_reg)
                    state_next = ST_HUNT;
                else if (n_unread < CNT_W'(FRAME_OVERHEAD))
                    state_next = ST_IDLE;
                else
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (n_ext < TOT_W'(rd_data) + TOT_W'(FRAME_OVERHEAD))
                    state_next = ST_IDLE;
                else
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (sum_end)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sum_reg != rd_data)
                    state_next = ST_HUNT;
                else if (len_reg == '0)
                    state_next = ST_EMPTY;
                else
                    state_next = ST_EMIT;
            end
            ST_EMPTY:
            begin
                if (emit_go)
                    state_next = ST_DONE;
            end
            ST_EMIT:
            begin
                if (emit_go && last_byte)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_HUNT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        remain_next  = remain_reg;
        cmd_next     = cmd_reg;
        res_cnt_next = res_cnt_reg;
        rd_en        = 1'b0;
        rd_off       = '0;
        load_out     = 1'b0;
        load_data    = '0;
        load_has     = 1'b0;
        load_last    = 1'b0;
        rx.ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                rx.ready = 1'b1;
                if (rx_fire)
                begin
                    res_cnt_next = '0;
                    if (rx.command == CMD_CLEAR)
                    begin
                        wp_next = '0;
                        rp_next = '0;
                    end
                    else
                    begin
                        wp_next = ptr_add(wp_reg, PTR_W'(1));
                        // full store: oldest byte is overwritten
                        if (rp_reg == wp_next)
                            rp_next = ptr_add(rp_reg, PTR_W'(1));
                    end
                end
            end
            ST_HUNT:
            begin
                rd_en  = n_unread >= CNT_W'(2);
                rd_off = '0;
            end
            ST_H0:
            begin
                if (rd_data != hdr_first_reg)
                    rp_next = ptr_add(rp_reg, PTR_W'(1));
                else
                begin
                    rd_en  = 1'b1;
                    rd_off = TOT_W'(1);
                end
            end
            ST_H1:
            begin
                if (rd_data != hdr_second_reg)
                    rp_next = ptr_add(rp_reg, PTR_W'(1));
                else if (n_unread >= CNT_W'(FRAME_OVERHEAD))
                begin
                    rd_en  = 1'b1;
                    rd_off = TOT_W'(LEN_OFFSET);
                end
            end
            ST_LEN:
            begin
                len_next = rd_data;
                idx_next = '0;
                sum_next = '0;
                rd_en    = 1'b1;
                rd_off   = '0;
            end
            ST_SUM:
            begin
                sum_next = sum_new;
                if (idx_reg == TOT_W'(ID_OFFSET))
                    id_next = rd_data;
                if (idx_reg == TOT_W'(REMAIN_OFFSET))
                    remain_next = rd_data;
                if (idx_reg == TOT_W'(CMD_OFFSET))
                    cmd_next = rd_data;
                rd_en = 1'b1;
                if (sum_end)
                    rd_off = chk_idx + TOT_W'(1);
                else
                begin
                    idx_next = idx_reg + TOT_W'(1);
                    rd_off   = idx_reg + TOT_W'(1);
                end
            end
            ST_CHK:
            begin
                if (sum_reg != rd_data)
                    rp_next = ptr_add(rp_reg, PTR_W'(HEADER_BYTES));
                else if (len_reg != '0)
                begin
                    idx_next = '0;
                    rd_en    = 1'b1;
                    rd_off   = TOT_W'(DATA_OFFSET);
                end
            end
            ST_EMPTY:
            begin
                if (emit_go)
                begin
                    load_out  = !drop;
                    load_last = 1'b1;
                    if (!drop)
                        res_cnt_next = res_cnt_reg + RES_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    load_out  = !drop;
                    load_data = rd_data;
                    load_has  = 1'b1;
                    load_last = last_byte;
                    if (!drop)
                        res_cnt_next = res_cnt_reg + RES_W'(1);
                    if (!last_byte)
                    begin
                        idx_next = idx_reg + TOT_W'(1);
                        rd_en    = 1'b1;
                        rd_off   = idx_reg + TOT_W'(1) + TOT_W'(DATA_OFFSET);
                    end
                end
            end
            ST_DONE:
            begin
                rp_next = ptr_add(rp_reg, total[PTR_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            hdr_first_reg  <= HEADER_FIRST_RESET;
            hdr_second_reg <= HEADER_SECOND_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_HEADER_FIRST)
                    hdr_first_reg <= cfg.data;
                else if (cfg.index == CFG_HEADER_SECOND)
                    hdr_second_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        len_reg    <= len_next;
        id_reg     <= id_next;
        remain_reg <= remain_next;
        cmd_reg    <= cmd_next;
        if (load_out)
        begin
            out_id_reg     <= id_reg;
            out_remain_reg <= remain_reg;
            out_cmd_reg    <= cmd_reg;
            out_len_reg    <= len_reg;
            out_data_reg   <= load_data;
            out_has_reg    <= load_has;
            out_last_reg   <= load_last;
        end
    end

    assign cfg.ready        = 1'b1;
    assign res.valid        = out_valid_reg;
    assign res.packet_id    = out_id_reg;
    assign res.remain_count = out_remain_reg;
    assign res.command_code = out_cmd_reg;
    assign res.data_length  = out_len_reg;
    assign res.data_byte    = out_data_reg;
    assign res.has_data     = out_has_reg;
    assign res.last         = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/rbpd_checker.sv =====
// ----------------------------------------------------------------------------
// rbpd_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpd_checker
    import rbpd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rx_valid,
    input wire logic              rx_ready,
    input wire logic              rx_command,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [BYTE_W-1:0] res_data_length,
    input wire logic [BYTE_W-1:0] res_data_byte,
    input wire logic              res_has_data,
    input wire logic              res_last
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data_byte)
            && $stable(res_last) && $stable(res_has_data))
        else $error("result changed while stalled");

    // a written byte starts a scan, so the block goes busy
    a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && rx_command == CMD_WRITE |=> !rx_ready)
        else $error("ready after a written byte");

    // a clear needs no scan
    a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && rx_command == CMD_CLEAR |=> rx_ready)
        else $error("busy after clear");

    // a result without data is the last one and has zero length
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_has_data |-> res_last && res_data_length == '0)
        else $error("malformed empty-frame result");

endmodule

bind ring_buffer_packet_deframer rbpd_checker u_rbpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (rx.valid),
    .rx_ready        (rx.ready),
    .rx_command      (rx.command),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_data_length (res.data_length),
    .res_data_byte   (res.data_byte),
    .res_has_data    (res.has_data),
    .res_last        (res.last)
);

`default_nettype wire

// ===== tb/ring_buffer_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_packet_deframer_tb
// Byte items go in through the rx channel and are fed to a local deframer
// model that keeps its own ring store. Frame results are checked field by
// field against it, under several header settings, idle mixes and one long
// receiver stall.
// ----------------------------------------------------------------------------

module ring_buffer_packet_deframer_tb;

    import rbpd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 20;      // margin once the block is back in idle
    localparam int HOLD_CYCLES   = 400;
    localparam int FULL_FRAME    = 1000;
    localparam int TIMEOUT_NS    = 8_000_000;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_id;
        logic [BYTE_W-1:0] remain_count;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] data_length;
        logic [BYTE_W-1:0] data_byte;
        logic              has_data;
        logic              last;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rbpd_rx_if  rx ();
    rbpd_res_if res ();
    rbpd_cfg_if cfg ();

    ring_buffer_packet_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    rx_item_t          pending_items[$];
    frame_result_t     expected_results[$];
    logic [BYTE_W-1:0] payload_bytes[$];

    // local deframer state
    logic [BYTE_W-1:0] byte_store[STORE_DEPTH];
    int                wr_ptr;
    int                rd_ptr;
    logic [BYTE_W-1:0] hdr_first;
    logic [BYTE_W-1:0] hdr_second;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_served;
    int hold_left;

    int bytes_queued;
    int items_sent;
    int clears_sent;
    int frames_seen;
    int results_checked;
    int error_count;

    task automatic log_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [BYTE_W-1:0] stored_at(input int off);
        return byte_store[(rd_ptr + off) % STORE_DEPTH];
    endfunction

    // one accepted item: write and rescan until nothing more can be consumed
    task automatic deframe_byte(input logic cmd, input logic [BYTE_W-1:0] value);
        int                unread_n;
        int                len;
        int                total;
        int                produced;
        int                i;
        bit                progress;
        logic [BYTE_W-1:0] sum;
        frame_result_t     r;
        if (cmd == CMD_CLEAR) begin
            wr_ptr = 0;
            rd_ptr = 0;
            return;
        end
        byte_store[wr_ptr] = value;
        wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
        if (rd_ptr == wr_ptr)
            rd_ptr = (rd_ptr + 1) % STORE_DEPTH;   // full: oldest byte lost
        produced = 0;
        progress = 1'b1;
        while (progress) begin
            progress = 1'b0;
            unread_n = (wr_ptr + STORE_DEPTH - rd_ptr) % STORE_DEPTH;
            while (unread_n >= 2 &&
                   !(stored_at(0) == hdr_first && stored_at(1) == hdr_second)) begin
                rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
                unread_n--;
            end
            if (unread_n >= FRAME_OVERHEAD) begin
                len   = stored_at(LEN_OFFSET);
                total = len + FRAME_OVERHEAD;
                if (unread_n >= total) begin
                    progress = 1'b1;
                    sum = '0;
                    for (i = 0; i <= len + LEN_OFFSET; i++)
                        sum ^= stored_at(i);
                    if (sum != stored_at(len + DATA_OFFSET)) begin
                        rd_ptr = (rd_ptr + HEADER_BYTES) % STORE_DEPTH;
                    end
                    else begin
                        frames_seen++;
                        r.packet_id    = stored_at(ID_OFFSET);
                        r.remain_count = stored_at(REMAIN_OFFSET);
                        r.command_code = stored_at(CMD_OFFSET);
                        r.data_length  = stored_at(LEN_OFFSET);
                        if (len == 0) begin
                            r.data_byte = '0;
                            r.has_data  = 1'b0;
                            r.last      = 1'b1;
                            if (produced < MAX_RESULTS) begin
                                expected_results.push_back(r);
                                produced++;
                            end
                        end
                        else begin
                            for (i = 0; i < len; i++) begin
                                r.data_byte = stored_at(DATA_OFFSET + i);
                                r.has_data  = 1'b1;
                                r.last      = (i + 1 == len);
                                if (produced < MAX_RESULTS) begin
                                    expected_results.push_back(r);
                                    produced++;
                                end
                            end
                        end
                        rd_ptr = (rd_ptr + total) % STORE_DEPTH;
                    end
                end
            end
        end
    endtask

    task automatic queue_byte(input logic cmd, input logic [BYTE_W-1:0] value);
        rx_item_t it;
        it.command = cmd;
        it.rx_byte = value;
        pending_items.push_back(it);
        bytes_queued++;
    endtask

    // payload comes from payload_bytes first, then random; keep cuts the frame short
    task automatic queue_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] remain,
                               input logic [BYTE_W-1:0] code, input int len,
                               input logic [BYTE_W-1:0] flip, input int keep);
        logic [BYTE_W-1:0] frame_bytes[$];
        logic [BYTE_W-1:0] check;
        int                i;
        frame_bytes = {hdr_first, hdr_second, id, remain, code, BYTE_W'(len)};
        for (i = 0; i < len; i++) begin
            if (payload_bytes.size() != 0)
                frame_bytes.push_back(payload_bytes.pop_front());
            else
                frame_bytes.push_back(BYTE_W'($urandom));
        end
        check = '0;
        for (i = 0; i < frame_bytes.size(); i++)
            check ^= frame_bytes[i];
        frame_bytes.push_back(check ^ flip);
        for (i = 0; i < frame_bytes.size() && i < keep; i++)
            queue_byte(CMD_WRITE, frame_bytes[i]);
    endtask

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(3))
            0:       return hdr_first;
            1:       return hdr_second;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // mostly good frames; the rest bad checks, cut frames, noise, frames after a stray header byte and clears
    task automatic random_traffic(input int item_target);
        int start_count;
        int pick;
        int len;
        start_count = bytes_queued;
        while (bytes_queued - start_count < item_target) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            if (pick < 62)
                queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                            len, '0, FULL_FRAME);
            else if (pick < 72)
                queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                            len, BYTE_W'($urandom_range(1, 255)), FULL_FRAME);
            else if (pick < 80)
                queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                            len, '0, $urandom_range(1, len + FRAME_OVERHEAD - 1));
            else if (pick < 92)
                repeat ($urandom_range(1, 4)) queue_byte(CMD_WRITE, noise_byte());
            else if (pick < 96) begin
                queue_byte(CMD_WRITE, hdr_first);
                queue_frame(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                            len, '0, FULL_FRAME);
            end
            else
                queue_byte(CMD_CLEAR, BYTE_W'($urandom));
        end
    endtask

    task automatic write_header_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_HEADER_FIRST)
            hdr_first = value;
        else if (idx == CFG_HEADER_SECOND)
            hdr_second = value;
    endtask

    // everything sent and answered, then wait for the trailing rescan to end
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin : rx_driver
        rx_item_t taken;
        if (rst_n) begin
            if (rx.valid && rx.ready) begin
                taken = pending_items.pop_front();
                items_sent++;
                if (taken.command == CMD_CLEAR)
                    clears_sent++;
                deframe_byte(taken.command, taken.rx_byte);
            end
            if (!rx.valid || rx.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    rx.valid   <= 1'b1;
                    rx.command <= pending_items[0].command;
                    rx.rx_byte <= pending_items[0].rx_byte;
                end
                else
                    rx.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : receiver_hold
        if (hold_request != hold_served) begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk) begin : res_monitor
        frame_result_t got;
        frame_result_t want;
        if (rst_n) begin
            if (res.valid && res.ready) begin
                got = {res.packet_id, res.remain_count, res.command_code, res.data_length,
                       res.data_byte, res.has_data, res.last};
                if (expected_results.size() == 0)
                    log_mismatch($sformatf("unexpected result %p", got));
                else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got !== want)
                        log_mismatch($sformatf("result %0d: got %p, want %p",
                                               results_checked, got, want));
                end
            end
            res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rx.valid      = 1'b0;
        rx.command    = CMD_WRITE;
        rx.rx_byte    = '0;
        res.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_HEADER_FIRST;
        cfg.data      = '0;
        hold_request  = 0;
        hold_served   = 0;
        hold_left     = 0;
        wr_ptr        = 0;
        rd_ptr        = 0;
        hdr_first     = HEADER_FIRST_RESET;
        hdr_second    = HEADER_SECOND_RESET;
        send_idle_pct = 18;
        recv_idle_pct = 52;
        bytes_queued  = 0;
        items_sent    = 0;
        clears_sent   = 0;
        frames_seen   = 0;
        results_checked = 0;
        error_count   = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty frame at field maxima, a lone byte ahead of a frame
        // at field minima, a bad check, then a clear over a bare header pair
        queue_frame(8'hFF, 8'hFF, 8'hFF, 0, '0, FULL_FRAME);
        queue_byte(CMD_WRITE, 8'h00);
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'hFF);
        queue_frame(8'h00, 8'h00, 8'h00, 2, '0, FULL_FRAME);
        queue_frame(8'h5A, 8'hA5, 8'h3C, 0, 8'h01, FULL_FRAME);
        queue_byte(CMD_WRITE, hdr_first);
        queue_byte(CMD_WRITE, hdr_second);
        queue_byte(CMD_CLEAR, 8'hFF);
        wait_idle();

        // headers at the extremes; longest frame that can still complete
        write_header_reg(CFG_HEADER_FIRST, 8'h00);
        write_header_reg(CFG_HEADER_SECOND, 8'hFF);
        queue_frame(8'h81, 8'h42, 8'h24, STORE_DEPTH - 1 - FRAME_OVERHEAD, '0, FULL_FRAME);
        random_traffic(55);
        wait_idle();

        // swapped extremes; frames too long for the store
        send_idle_pct = 52;
        recv_idle_pct = 18;
        write_header_reg(CFG_HEADER_FIRST, 8'hFF);
        write_header_reg(CFG_HEADER_SECOND, 8'h00);
        queue_frame(8'h11, 8'h22, 8'h33, STORE_DEPTH - FRAME_OVERHEAD, '0, FULL_FRAME);
        queue_frame(8'h44, 8'h55, 8'h66, 255, '0, 20);
        random_traffic(45);
        wait_idle();

        // equal header bytes, no idling, and a long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_header_reg(CFG_HEADER_FIRST, 8'h7E);
        write_header_reg(CFG_HEADER_SECOND, 8'h7E);
        @(posedge clk);
        hold_request <= hold_request + 1;
        random_traffic(90);
        wait_idle();

        if (expected_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d items (%0d clears) over four header settings and three idle mixes.",
                 items_sent, clears_sent);
        $display("Checked %0d results from %0d good frames, incl. a %0d-cycle receiver stall.",
                 results_checked, frames_seen, HOLD_CYCLES);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rbpd_pkg.sv
rtl/rbpd_intf.sv
rtl/rbpd_ram.sv
rtl/ring_buffer_packet_deframer.sv
rtl/rbpd_checker.sv
tb/ring_buffer_packet_deframer_tb.sv
